[sv/ipmwu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipmwu_pkg: shared types and constants
// Widths, dimension limits, register indexes and the beat and control structs
// for the packed Ising word update.
// ----------------------------------------------------------------------------
package ipmwu_pkg;

  localparam int WORD_W     = 32;
  localparam int LANES      = 32;
  localparam int LANE_IDX_W = 5;
  localparam int CNT_W      = 4;
  localparam int DIM_W      = 3;
  localparam int ADD_W      = 2;
  localparam int TABLE_W    = 32;
  localparam int CFG_IDX_W  = 1;

  // Dimensions below CUBE_DIMS live inside the packed cube.
  localparam logic [DIM_W-1:0] CUBE_DIMS = 3'd5;
  // Beats at or above MAX_DIMS contribute nothing.
  localparam logic [DIM_W-1:0] MAX_DIMS  = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_TARGET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_TABLE  = 1'd1;

  localparam logic [TABLE_W-1:0] ACCEPT_TABLE_RESET = 32'd8355712;

  typedef struct packed {
    logic [WORD_W-1:0] center_word;
    logic [WORD_W-1:0] lower_word;
    logic [WORD_W-1:0] upper_word;
    logic [DIM_W-1:0]  dimension_index;
    logic              coordinate_odd;
    logic              last_beat;
  } beat_t;

  typedef struct packed {
    logic accept;
    logic parity_now;
  } lane_ctrl_t;

endpackage

`default_nettype wire

[sv/ipmwu_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipmwu_lane: one spin lane
// Keeps the neighbor count of one spin and decides whether it flips on the
// final beat of a word.
// ----------------------------------------------------------------------------
module ipmwu_lane (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [ipmwu_pkg::LANE_IDX_W-1:0]    lane_idx,
  input  wire ipmwu_pkg::beat_t                    beat,
  input  wire ipmwu_pkg::lane_ctrl_t               ctrl,
  input  wire logic                                parity_target,
  input  wire logic [ipmwu_pkg::TABLE_W-1:0]       accept_table,
  output logic                                     flip
);

  logic [ipmwu_pkg::CNT_W-1:0]      count_r;
  logic [ipmwu_pkg::CNT_W-1:0]      count_nxt;
  logic [ipmwu_pkg::CNT_W-1:0]      count_sum;
  logic [ipmwu_pkg::LANE_IDX_W-1:0] partner;
  logic [ipmwu_pkg::LANE_IDX_W-1:0] shifted;
  logic [ipmwu_pkg::ADD_W-1:0]      add;
  logic [ipmwu_pkg::WORD_W-1:0]     side;
  logic                             in_cube;
  logic                             in_high;
  logic                             take_part;

  assign in_cube = beat.dimension_index < ipmwu_pkg::CUBE_DIMS;
  assign in_high = !in_cube && (beat.dimension_index < ipmwu_pkg::MAX_DIMS);

  always_comb begin
    shifted = lane_idx >> beat.dimension_index;
    partner = lane_idx ^ (ipmwu_pkg::LANE_IDX_W'(1) << beat.dimension_index);
    // The upper half of the cube along this dimension looks into the upper word.
    side    = shifted[0] ? beat.upper_word : beat.lower_word;
    if (in_cube) begin
      add = ipmwu_pkg::ADD_W'(beat.center_word[partner]) + ipmwu_pkg::ADD_W'(side[partner]);
    end else if (in_high) begin
      add = ipmwu_pkg::ADD_W'(beat.lower_word[lane_idx])
          + ipmwu_pkg::ADD_W'(beat.upper_word[lane_idx]);
    end else begin
      add = '0;
    end
  end

  assign count_sum = count_r + ipmwu_pkg::CNT_W'(add);

  assign take_part = (ctrl.parity_now ^ (^lane_idx)) == parity_target;
  assign flip = take_part && accept_table[{beat.center_word[lane_idx], count_sum}];

  always_comb begin
    count_nxt = count_r;
    if (ctrl.accept) begin
      count_nxt = beat.last_beat ? '0 : count_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/ipmwu_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipmwu_merge: parity tracking and result register
// Tracks coordinate parity across beats, gathers the lane flips into the new
// word and holds it in the output register.
// ----------------------------------------------------------------------------
module ipmwu_merge (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire ipmwu_pkg::beat_t                beat,
  input  wire logic [ipmwu_pkg::LANES-1:0]     flips,
  output ipmwu_pkg::lane_ctrl_t                ctrl,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [ipmwu_pkg::WORD_W-1:0]         new_word
);

  logic                         parity_r;
  logic                         parity_nxt;
  logic                         valid_r;
  logic                         valid_nxt;
  logic [ipmwu_pkg::WORD_W-1:0] word_r;
  logic                         high_dim;

  assign high_dim = (beat.dimension_index >= ipmwu_pkg::CUBE_DIMS)
                 && (beat.dimension_index <  ipmwu_pkg::MAX_DIMS);

  // Only a final beat needs room in the output register.
  assign in_ready        = !beat.last_beat || !valid_r || out_ready;
  assign ctrl.accept     = in_valid && in_ready;
  assign ctrl.parity_now = parity_r ^ (high_dim && beat.coordinate_odd);

  always_comb begin
    parity_nxt = parity_r;
    valid_nxt  = valid_r && !out_ready;
    if (ctrl.accept) begin
      parity_nxt = beat.last_beat ? 1'b0 : ctrl.parity_now;
      if (beat.last_beat) begin
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      parity_r <= parity_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept && beat.last_beat) begin
      word_r <= beat.center_word ^ flips;
    end
  end

  assign out_valid = valid_r;
  assign new_word  = word_r;

endmodule

`default_nettype wire

[sv/packed_ising_metropolis_word_update.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_ising_metropolis_word_update: checkerboard Metropolis word update
// Top level: configuration registers, 32 spin lanes and the merging stage.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle, one per lattice dimension of a
// word, unless a final beat is held back, and after the request marked as the
// last beat it presents the updated 32-spin word on the result channel in the
// next cycle. All 32 lane counters add their neighbor contributions in
// parallel, and the flip decisions for the final beat are made
// from the counts including that beat's own contribution. A result waits in a
// single output register; beats that are not final are accepted even while
// that register is full, and a final beat waits only if the previous result
// has not been taken in the same cycle. Configuration writes are always taken
// and should be issued only while no word is in progress.
// ----------------------------------------------------------------------------
module packed_ising_metropolis_word_update (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Beat requests.
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [ipmwu_pkg::WORD_W-1:0]       in_center_word,
  input  wire logic [ipmwu_pkg::WORD_W-1:0]       in_lower_word,
  input  wire logic [ipmwu_pkg::WORD_W-1:0]       in_upper_word,
  input  wire logic [ipmwu_pkg::DIM_W-1:0]        in_dimension_index,
  input  wire logic                               in_coordinate_odd,
  input  wire logic                               in_last_beat,
  // Updated words.
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [ipmwu_pkg::WORD_W-1:0]            out_new_word,
  // Register writes.
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ipmwu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ipmwu_pkg::TABLE_W-1:0]      cfg_data
);

  ipmwu_pkg::beat_t              beat;
  ipmwu_pkg::lane_ctrl_t         ctrl;
  logic [ipmwu_pkg::LANES-1:0]   flips;
  logic                          parity_target_r;
  logic                          parity_target_nxt;
  logic [ipmwu_pkg::TABLE_W-1:0] accept_table_r;
  logic [ipmwu_pkg::TABLE_W-1:0] accept_table_nxt;

  assign beat.center_word     = in_center_word;
  assign beat.lower_word      = in_lower_word;
  assign beat.upper_word      = in_upper_word;
  assign beat.dimension_index = in_dimension_index;
  assign beat.coordinate_odd  = in_coordinate_odd;
  assign beat.last_beat       = in_last_beat;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  always_comb begin
    parity_target_nxt = parity_target_r;
    accept_table_nxt  = accept_table_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ipmwu_pkg::REG_PARITY_TARGET: parity_target_nxt = cfg_data[0];
        ipmwu_pkg::REG_ACCEPT_TABLE:  accept_table_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_target_r <= 1'b0;
      accept_table_r  <= ipmwu_pkg::ACCEPT_TABLE_RESET;
    end else begin
      parity_target_r <= parity_target_nxt;
      accept_table_r  <= accept_table_nxt;
    end
  end

  // One lane per spin of the packed cube. Each lane sees the whole beat and
  // picks out its own neighbor bits from its index.
  for (genvar g = 0; g < ipmwu_pkg::LANES; g++) begin : g_lane
    ipmwu_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .lane_idx      (ipmwu_pkg::LANE_IDX_W'(g)),
      .beat          (beat),
      .ctrl          (ctrl),
      .parity_target (parity_target_r),
      .accept_table  (accept_table_r),
      .flip          (flips[g])
    );
  end

  // The merging stage owns the handshake, the coordinate parity and the
  // output register that holds the flipped word.
  ipmwu_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .beat      (beat),
    .flips     (flips),
    .ctrl      (ctrl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .new_word  (out_new_word)
  );

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for packed_ising_metropolis_word_update
// Streams dimension beats of packed spin words through the block. It predicts
// every updated word from its own model of the lane counters, coordinate
// parity and acceptance table, and compares the results in order. Both sides
// stall at random, and the register settings change between phases.
// ----------------------------------------------------------------------------
module testbench;
  import ipmwu_pkg::*;

  // Generous ceiling. The slowest legal run has about 1950 requests, each behind
  // the longest request gap and the longest result stall, plus one long hold.
  localparam int CYCLE_LIMIT = 500000;
  // Number of updated words taken before the receiver holds off for a long time.
  localparam int HOLD_AT     = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 40;

  // Expected-word model. It keeps its own copy of the registers, the 32 lane
  // counters and the running coordinate parity, and queues the updated words.
  class word_update_predictor;
    logic                parity_target;
    logic [TABLE_W-1:0]  accept_table;
    logic [CNT_W-1:0]    lane_count [LANES];
    logic                coord_parity;
    logic [WORD_W-1:0]   expected_words [$];
    int                  errors;
    int                  words_checked;

    function new();
      parity_target = 1'b0;
      accept_table  = ACCEPT_TABLE_RESET;
      errors        = 0;
      words_checked = 0;
      clear_lanes();
    endfunction

    function void clear_lanes();
      foreach (lane_count[i]) lane_count[i] = '0;
      coord_parity = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [TABLE_W-1:0] data);
      if (index == REG_PARITY_TARGET) parity_target = data[0];
      else if (index == REG_ACCEPT_TABLE) accept_table = data;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void note_beat(logic [WORD_W-1:0] center, logic [WORD_W-1:0] lower,
                            logic [WORD_W-1:0] upper, logic [DIM_W-1:0] dim,
                            logic odd, logic last);
      logic [LANE_IDX_W-1:0] lane;
      logic [LANE_IDX_W-1:0] partner;
      logic [WORD_W-1:0]     side;
      logic [WORD_W-1:0]     word;
      logic [4:0]            table_bit;
      if (dim < CUBE_DIMS) begin
        // Inside the cube the partner spin sits in the same word or in the
        // neighbor word, depending on which half of the cube the lane is in.
        for (int i = 0; i < LANES; i++) begin
          lane    = i[LANE_IDX_W-1:0];
          partner = lane ^ (LANE_IDX_W'(1) << dim);
          side    = lane[dim] ? upper : lower;
          lane_count[i] = lane_count[i] + {3'b000, center[partner]}
                                        + {3'b000, side[partner]};
        end
      end else if (dim < MAX_DIMS) begin
        for (int i = 0; i < LANES; i++) begin
          lane_count[i] = lane_count[i] + {3'b000, lower[i]} + {3'b000, upper[i]};
        end
        coord_parity = coord_parity ^ odd;
      end
      if (last) begin
        word = center;
        for (int i = 0; i < LANES; i++) begin
          lane = i[LANE_IDX_W-1:0];
          if ((coord_parity ^ (^lane)) == parity_target) begin
            table_bit = {center[i], lane_count[i]};
            if (accept_table[table_bit]) word[i] = ~word[i];
          end
        end
        expected_words.push_back(word);
        clear_lanes();
      end
    endfunction

    function void check_word(logic [WORD_W-1:0] actual);
      logic [WORD_W-1:0] want;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, actual %h", $time, actual);
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (actual !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: new_word mismatch, expected %h, actual %h", $time, want, actual);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [WORD_W-1:0]    in_center_word = '0;
  logic [WORD_W-1:0]    in_lower_word = '0;
  logic [WORD_W-1:0]    in_upper_word = '0;
  logic [DIM_W-1:0]     in_dimension_index = '0;
  logic                 in_coordinate_odd = 1'b0;
  logic                 in_last_beat = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_W-1:0]    out_new_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PARITY_TARGET;
  logic [TABLE_W-1:0]   cfg_data = '0;

  word_update_predictor predictor;
  int beats_taken = 0;
  int cfg_writes = 0;
  int cycle_count = 0;
  int in_quiet_left = 0;
  int out_quiet_left = 0;

  packed_ising_metropolis_word_update i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_center_word     (in_center_word),
    .in_lower_word      (in_lower_word),
    .in_upper_word      (in_upper_word),
    .in_dimension_index (in_dimension_index),
    .in_coordinate_odd  (in_coordinate_odd),
    .in_last_beat       (in_last_beat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_new_word       (out_new_word),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A single watcher handles register writes, requests and results in that
  // order, so an expectation is always queued before its word can be checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        predictor.write_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        predictor.note_beat(in_center_word, in_lower_word, in_upper_word,
                            in_dimension_index, in_coordinate_odd, in_last_beat);
        beats_taken++;
      end
      if (out_valid && out_ready) predictor.check_word(out_new_word);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding",
               cycle_count, predictor.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Gap before the next request or result. Now and then a quiet stretch of
  // back-to-back traffic is drawn so that full-rate streaming is covered too.
  function automatic int draw_gap(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Random spin pattern with a chosen density of up spins, so that lane
  // counts reach both ends of their range and not only the middle.
  function automatic logic [WORD_W-1:0] rand_spins(int unsigned density);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    a = $urandom;
    b = $urandom;
    c = $urandom;
    case (density)
      0:       return '0;
      1:       return a & b & c;
      2:       return a;
      3:       return a | b | c;
      default: return '1;
    endcase
  endfunction

  // Offers one request and returns at the edge where it is taken. Valid is
  // left high so that a following request with no gap keeps it asserted.
  task automatic send_beat(input logic [WORD_W-1:0] center, input logic [WORD_W-1:0] lower,
                           input logic [WORD_W-1:0] upper, input logic [DIM_W-1:0] dim,
                           input logic odd, input logic last);
    int gap;
    gap = draw_gap(in_quiet_left);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_center_word     <= center;
    in_lower_word      <= lower;
    in_upper_word      <= upper;
    in_dimension_index <= dim;
    in_coordinate_odd  <= odd;
    in_last_beat       <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Valid is left high; the caller lowers it after the last write of a group.
  task automatic program_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [TABLE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Every phase ends on a last beat, so once all words are back the lanes
  // are clear. A few more cycles let any final beat with no result settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predictor.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Most words are well formed: each dimension at most once, in random order,
  // with one center word. The rest are noise: any dimension, repeated ones,
  // dimension 7, a fresh center on every beat and lengths from 1 to 12.
  task automatic send_random_word();
    int unsigned order [7];
    int unsigned count;
    int unsigned pick;
    int unsigned tmp;
    int unsigned density;
    logic [WORD_W-1:0] center;
    if ($urandom_range(0, 3) != 0) begin
      for (int k = 0; k < 7; k++) order[k] = k;
      for (int k = 6; k > 0; k--) begin
        pick = $urandom_range(0, k);
        tmp = order[k];
        order[k] = order[pick];
        order[pick] = tmp;
      end
      count   = $urandom_range(5, 7);
      density = $urandom_range(0, 4);
      center  = rand_spins($urandom_range(0, 4));
      for (int k = 0; k < count; k++) begin
        send_beat(center, rand_spins(density), rand_spins(density), DIM_W'(order[k]),
                  1'($urandom), k == count - 1);
      end
    end else begin
      count = $urandom_range(1, 12);
      for (int k = 0; k < count; k++) begin
        send_beat(rand_spins($urandom_range(0, 4)), rand_spins($urandom_range(0, 4)),
                  rand_spins($urandom_range(0, 4)), DIM_W'($urandom_range(0, 7)),
                  1'($urandom), k == count - 1);
      end
    end
  endtask

  // Result side. Each word waits a random number of cycles before ready goes
  // high. Once, after HOLD_AT words, ready stays low for a long stretch while
  // the sender keeps going, so the output register fills and the input stalls.
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(out_quiet_left);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      taken++;
    end
  end

  initial begin
    logic              phase_parity [5];
    logic [TABLE_W-1:0] phase_table [5];
    int                target;
    predictor = new();

    // Table extremes first, then a random table, then the reset value with the
    // other sublattice, then one more random table.
    phase_parity[0] = 1'b1;  phase_table[0] = '1;
    phase_parity[1] = 1'b0;  phase_table[1] = '0;
    phase_parity[2] = 1'b1;  phase_table[2] = $urandom;
    phase_parity[3] = 1'b1;  phase_table[3] = ACCEPT_TABLE_RESET;
    phase_parity[4] = 1'b0;  phase_table[4] = $urandom;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, under the reset register values.
    // A word of a single beat, all spins down.
    send_beat('0, '0, '0, DIM_W'(0), 1'b0, 1'b1);
    // A full word over all seven dimensions with every spin up and odd
    // coordinates in the two outer dimensions.
    for (int d = 0; d < 7; d++) begin
      send_beat('1, '1, '1, DIM_W'(d), 1'b1, d == 6);
    end
    // Lane overflow: eight outer beats with all neighbors up add 16 to each
    // lane, which wraps to zero. The word closes on a dimension past the
    // limit, which adds nothing but still emits.
    for (int k = 0; k < 8; k++) begin
      send_beat('1, '1, '1, DIM_W'(6), k[0], 1'b0);
    end
    send_beat(32'hA5C3_0FF0, '1, '1, DIM_W'(7), 1'b1, 1'b1);
    // Cube dimensions only, with alternating patterns across the halves.
    for (int d = 0; d < 5; d++) begin
      send_beat(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, DIM_W'(d), 1'b0, d == 4);
    end
    drain();

    for (int p = 0; p < 5; p++) begin
      program_reg(REG_PARITY_TARGET, TABLE_W'(phase_parity[p]));
      program_reg(REG_ACCEPT_TABLE, phase_table[p]);
      cfg_valid <= 1'b0;
      target = 22 + (p + 1) * 386;
      while (beats_taken < target) send_random_word();
      drain();
    end

    $display("Covered %0d requests, %0d updated words and %0d register writes",
             beats_taken, predictor.words_checked, cfg_writes);
    $display("across six register settings, with random stalls and one long output hold.");
    if (predictor.errors == 0 && predictor.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
